// File: design/bec_pkg.sv
// ----------------------------------------------------------------------------
// bec_pkg
// Shared constants and types for the 3x3 cross binary erosion block.
// ----------------------------------------------------------------------------
package bec_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_W     = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    localparam logic [PIX_W-1:0] WHITE = 8'hFF;
    localparam logic [PIX_W-1:0] BLACK = 8'h00;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd950;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd950;
    localparam logic [CFG_W-1:0] SIZE_MIN   = 11'd3;
    localparam logic [CFG_W-1:0] WIDTH_MAX  = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] HEIGHT_MAX = CFG_W'(MAX_HEIGHT);

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // everything one pixel produces: up to two beats
    typedef struct packed {
        logic has_first;    // pixel one row above
        logic first_white;
        logic has_second;   // own border zero on the last row
        logic done;         // second beat closes the frame
        logic eroded;       // frame summary, only with done
    } t_result;

endpackage

// File: design/bec_front.sv
// ----------------------------------------------------------------------------
// bec_front
// Pixel intake: counters, line stores, cross window and erosion decision.
// ----------------------------------------------------------------------------
module bec_front
    import bec_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_result              o_result
);

    logic [CFG_W-1:0] r_width, r_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_eroded;
    logic             r_left;
    // line store entry: {older row white, previous row white}
    logic [1:0]       r_lines [MAX_WIDTH];
    logic [1:0]       r_win_cur;   // entry at current column
    logic [1:0]       r_win_nxt;   // entry one column right

    logic [CFG_W-1:0] w_use, h_use, col_ext, row_ext;
    logic             accept, cur, mid, up, right;
    logic             row_end, last_row, has_row_above, interior;
    logic             keep, eroded_now;
    logic [COL_W-1:0] n_col, n_col_rt;

    always_comb begin
        w_use = (r_width < SIZE_MIN) ? SIZE_MIN :
                (r_width > WIDTH_MAX) ? WIDTH_MAX : r_width;
        h_use = (r_height < SIZE_MIN) ? SIZE_MIN :
                (r_height > HEIGHT_MAX) ? HEIGHT_MAX : r_height;
        col_ext = CFG_W'(r_col);
        row_ext = CFG_W'(r_row);

        cur   = (i_pixel == WHITE);
        mid   = r_win_cur[0];
        up    = r_win_cur[1];
        right = r_win_nxt[0];

        row_end       = col_ext >= (w_use - CFG_W'(1));
        last_row      = row_ext >= (h_use - CFG_W'(1));
        has_row_above = (r_row != '0);
        interior      = (r_row >= ROW_W'(2)) && (r_col != '0)
                        && ((col_ext + CFG_W'(2)) <= w_use);
        keep          = interior && mid && up && r_left && right && cur;
        eroded_now    = has_row_above && interior && mid && !keep;

        n_col    = row_end ? '0 : r_col + COL_W'(1);
        n_col_rt = n_col + COL_W'(1);

        o_ready = !i_q_full;
        accept  = i_valid && o_ready;
        o_push  = accept && (has_row_above || last_row);

        o_result.has_first   = has_row_above;
        o_result.first_white = keep;
        o_result.has_second  = last_row;
        o_result.done        = last_row && row_end;
        o_result.eroded      = last_row && row_end && (r_eroded || eroded_now);
    end

    // line stores and window prefetch for the next column
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lines[r_col] <= {mid, cur};
            r_win_cur      <= r_lines[n_col];
            r_win_nxt      <= r_lines[n_col_rt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_col    <= '0;
            r_row    <= '0;
            r_eroded <= 1'b0;
            r_left   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_WIDTH:  r_width  <= i_cfg_wdata;
                    REG_HEIGHT: r_height <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                r_col  <= n_col;
                r_left <= row_end ? 1'b0 : mid;
                if (row_end && last_row) begin
                    r_row    <= '0;
                    r_eroded <= 1'b0;
                end else begin
                    if (row_end) begin
                        r_row <= r_row + ROW_W'(1);
                    end
                    if (eroded_now) begin
                        r_eroded <= 1'b1;
                    end
                end
            end
        end
    end

endmodule

// File: design/bec_fifo.sv
// ----------------------------------------------------------------------------
// bec_fifo
// Short result queue between pixel intake and output sequencing.
// ----------------------------------------------------------------------------
module bec_fifo
    import bec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_data
);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (FIFO_AW+1)'(1);
                2'b01:   r_count <= r_count - (FIFO_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: design/bec_back.sv
// ----------------------------------------------------------------------------
// bec_back
// Output sequencer: turns queued results into one or two output beats.
// ----------------------------------------------------------------------------
module bec_back
    import bec_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_result          i_q_data,
    output logic             o_q_pop,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [PIX_W-1:0] o_tdata,
    output logic             o_tlast,
    output logic             o_done,
    output logic             o_eroded
);

    logic r_valid, r_pend;
    logic r_white, r_last, r_done, r_eroded;
    logic r_pdone, r_peroded;   // held for the pending border beat
    logic can_load;

    assign can_load = !r_valid || i_tready;
    assign o_q_pop  = can_load && !r_pend && i_q_valid;
    assign o_tvalid = r_valid;
    assign o_tdata  = r_white ? WHITE : BLACK;
    assign o_tlast  = r_last;
    assign o_done   = r_done;
    assign o_eroded = r_eroded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (can_load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (i_q_valid) begin
                r_valid <= 1'b1;
                r_pend  <= i_q_data.has_first && i_q_data.has_second;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load) begin
            if (r_pend) begin
                r_white  <= 1'b0;
                r_last   <= 1'b1;
                r_done   <= r_pdone;
                r_eroded <= r_peroded;
            end else if (i_q_valid) begin
                if (i_q_data.has_first) begin
                    r_white   <= i_q_data.first_white;
                    r_last    <= !i_q_data.has_second;
                    r_done    <= 1'b0;
                    r_eroded  <= 1'b0;
                    r_pdone   <= i_q_data.done;
                    r_peroded <= i_q_data.eroded;
                end else begin
                    r_white  <= 1'b0;
                    r_last   <= 1'b1;
                    r_done   <= i_q_data.done;
                    r_eroded <= i_q_data.eroded;
                end
            end
        end
    end

endmodule

// File: design/binary_erosion_cross.sv
// ----------------------------------------------------------------------------
// binary_erosion_cross
// Streaming 3x3 cross binary erosion with end-of-frame erosion flag.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_axis channel in raster order, one per beat; only
//   255 counts as white. Results leave on m_axis one row behind the input:
//   each pixel from the second row on yields the eroded pixel above it, and
//   each last-row pixel also yields its own border zero. tlast marks the
//   last beat caused by one input pixel; tuser[0] marks the final beat of
//   the frame and tuser[1] then tells whether any interior white pixel was eroded.
//   Width and height are set through the i_cfg write port between frames.
// Throughput: one pixel per clock while the result queue has room; last-row
//   pixels make two beats each, so there the output port limits the rate.
// Path: a pixel's result is written into the result queue, then loaded into
//   the output register that drives m_axis.
// Stalls: a four-entry result queue decouples intake from output; when it
//   fills, s_axis_tready drops until m_axis drains it.
// Reset (synchronous, active low): counters, flags and queue clear; size
//   registers return to 950 x 950. Line stores are not cleared.
// ----------------------------------------------------------------------------
module binary_erosion_cross
    import bec_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // pixel input
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel
    // result output
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PIX_W-1:0]     m_axis_tdata,   // [7:0] out_pixel
    output logic                 m_axis_tlast,   // last_of_run
    output logic [1:0]           m_axis_tuser    // [0] frame_done, [1] any_eroded
);

    t_result front_res, q_res;
    logic    push, q_full, q_valid, q_pop;

    // intake: counters, line stores and window
    bec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_pixel    (s_axis_tdata),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_result   (front_res)
    );

    bec_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (front_res),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_res)
    );

    // output: splits last-row results into two beats
    bec_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_data (q_res),
        .o_q_pop  (q_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_done   (m_axis_tuser[0]),
        .o_eroded (m_axis_tuser[1])
    );

    // frame end always closes a pixel's run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("frame_done without tlast");

    // erosion summary only on the frame's final beat
    a_eroded_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("any_eroded outside frame end");

    // the frame's final beat carries black
    a_done_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == BLACK)
        else $error("frame end beat not black");

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("result queue overflow");

endmodule
